// ===== rtl/fahq_pkg.sv =====
// fahq_pkg: shared constants and types for the four-ary min-heap queue
// no dependencies
`timescale 1ns / 1ps
package fahq_pkg;
   localparam int TAG_W = 20;
   localparam int KEY_W = 31;
   localparam int ENT_W = TAG_W + KEY_W;
   localparam int CNT_W = 11;
   // fan-out of the heap; index math uses shifts, so keep it a power of two
   localparam int ARITY = 4;
   localparam int LOG_ARITY = 2;
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic kind;
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0] out_tag;
      logic [KEY_W-1:0] out_key;
      logic pop_valid;
      logic push_dropped;
      logic [CNT_W-1:0] fill_count;
   } rsp_type;

   // datapath operations driven by the controller
   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_DROP, OP_PUSH_START, OP_UP_STEP, OP_WR_HOLE,
      OP_RD_ROOT, OP_TAKE_ROOT, OP_LOAD_LAST, OP_CH_CMP, OP_DN_STEP
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic full;
      logic empty;
      logic at_root;
      logic up_swap;
      logic up_top;
      logic last_one;
      logic child_first;
      logic child_next;
      logic down_swap;
      logic best_first;
   } sts_type;
endpackage

// ===== rtl/fahq_if.sv =====
// fahq_if: valid/ready channel carrying one payload item
// depends on nothing
`timescale 1ns / 1ps
interface fahq_if #(parameter int W = 1);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/four_ary_min_heap_queue.sv =====
// four_ary_min_heap_queue: top level of the 4-ary min-heap priority queue
// depends on fahq_pkg, fahq_if, fahq_ctrl, fahq_dp, fahq_ram
//
// req channel carries one item {kind, tag, key}: kind 0 pushes, kind 1 pops
// the minimum. rsp channel returns one item per request with the popped
// entry, pop_valid, push_dropped and the fill count after the operation.
// csr_we/csr_wdata write capacity_limit; values above DEPTH act as DEPTH.
// one item is in work at a time. a dropped push or an empty pop goes
// straight to the result; a push compares one parent per step up the
// heap; a pop that empties the queue ends once the root is taken; other
// pops load the last entry at the root and, per level visited, compare
// one child per step and then decide the move.
// the heap memory has one registered read port.
// the result is held until rsp_ready; no new item is taken while it waits.
// synchronous reset empties the queue and sets the capacity to 1024;
// memory contents are not cleared.
`timescale 1ns / 1ps
module four_ary_min_heap_queue
   import fahq_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic clock,
   input  logic reset,
   fahq_if.sink req,
   fahq_if.source rsp,
   input  logic csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_d;
   logic req_ready, rsp_valid, req_fire;

   assign req_fire = req.valid && req_ready;
   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;
   assign rsp.data = rsp_d;

   fahq_ctrl u_ctrl (.clock(clock), .reset(reset), .req_fire(req_fire),
      .req_ready(req_ready), .rsp_valid(rsp_valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .sts(sts));

   fahq_dp #(.DEPTH(DEPTH)) u_dp (.clock(clock), .reset(reset),
      .cmd(cmd), .sts(sts), .req(req_type'(req.data)), .csr_we(csr_we),
      .csr_wdata(csr_wdata), .rsp(rsp_d));
endmodule

// ===== rtl/fahq_ram.sv =====
// fahq_ram: generic single-port write, single-port registered read memory
// depends on nothing
`timescale 1ns / 1ps
module fahq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/fahq_dp.sv =====
// fahq_dp: heap datapath, memory, index arithmetic, compares and counters
// depends on fahq_pkg and fahq_ram
`timescale 1ns / 1ps
module fahq_dp
   import fahq_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req,
   input  logic csr_we,
   input  logic [CNT_W-1:0] csr_wdata,
   output rsp_type rsp
);
   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);
   localparam int PW = NW + LOG_ARITY + 1;
   localparam int MW = (NW > CNT_W) ? NW : CNT_W;
   localparam int JW = LOG_ARITY + 1;

   logic [NW-1:0] count_ff, count_in, cap_eff;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [PW-1:0] pos_ff, pos_in, best_ff, best_in;
   logic [JW-1:0] j_ff, j_in;
   entry_type cur_ff, cur_in, best_e_ff, best_e_in, rd_data, wr_data;
   logic found_ff, found_in, is_pop_ff, is_pop_in;
   rsp_type rsp_ff, rsp_in;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [PW-1:0] count_ext, kid_base, kid_pos, up_calc, best_base;

   fahq_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign cap_eff = (MW'(cap_ff) > MW'(DEPTH)) ? NW'(DEPTH) : NW'(cap_ff);
   assign count_ext = PW'(count_ff);
   assign kid_base = pos_ff << LOG_ARITY;
   assign kid_pos = kid_base + PW'(j_ff);
   assign best_base = best_ff << LOG_ARITY;
   assign up_calc = (pos_ff - PW'(1)) >> LOG_ARITY;

   always_comb begin
      sts.is_pop = is_pop_ff;
      sts.full = (count_ff >= cap_eff);
      sts.empty = (count_ff == '0);
      sts.at_root = (pos_ff == '0);
      sts.up_swap = (cur_ff.key < rd_data.key);
      sts.up_top = (up_calc == '0);
      sts.last_one = (count_ff == NW'(1));
      sts.child_first = ((kid_base + PW'(1)) < count_ext);
      sts.child_next = (j_ff < JW'(ARITY)) && ((kid_pos + PW'(1)) < count_ext);
      sts.down_swap = found_ff && (best_e_ff.key < cur_ff.key);
      sts.best_first = ((best_base + PW'(1)) < count_ext);
   end

   always_comb begin
      count_in = count_ff; cap_in = csr_we ? csr_wdata : cap_ff;
      pos_in = pos_ff; best_in = best_ff; j_in = j_ff;
      cur_in = cur_ff; best_e_in = best_e_ff; found_in = found_ff;
      is_pop_in = is_pop_ff; rsp_in = rsp_ff;
      wr_en = 1'b0; wr_addr = AW'(pos_ff); wr_data = cur_ff; rd_addr = AW'(pos_ff);
      case (cmd.op)
         OP_LOAD: begin
            is_pop_in = req.kind;
            cur_in.tag = req.tag; cur_in.key = req.key;
            pos_in = PW'(count_ff);
            rsp_in = '0;
            rsp_in.fill_count = CNT_W'(count_ff);
         end
         OP_DROP: begin
            rsp_in.push_dropped = 1'b1;
         end
         OP_PUSH_START: begin
            // new entry sits in a hole at the end; fetch its parent
            count_in = count_ff + NW'(1);
            rsp_in.fill_count = CNT_W'(count_ff + NW'(1));
            rd_addr = AW'(up_calc);
         end
         OP_UP_STEP: begin
            // when the new key is smaller, the parent moves down into the hole and the next parent is fetched
            if (cur_ff.key < rd_data.key) begin
               wr_en = 1'b1; wr_data = rd_data;
               pos_in = up_calc;
               rd_addr = AW'((up_calc - PW'(1)) >> LOG_ARITY);
            end
         end
         OP_WR_HOLE: begin
            wr_en = 1'b1;
         end
         OP_RD_ROOT: begin
            rd_addr = '0;
         end
         OP_TAKE_ROOT: begin
            // root data arrives now; fetch the last entry
            rsp_in.out_tag = rd_data.tag; rsp_in.out_key = rd_data.key;
            rsp_in.pop_valid = 1'b1;
            count_in = count_ff - NW'(1);
            rsp_in.fill_count = CNT_W'(count_ff - NW'(1));
            rd_addr = AW'(count_ff - NW'(1));
            pos_in = '0;
         end
         OP_LOAD_LAST: begin
            cur_in = rd_data;
            j_in = JW'(1); found_in = 1'b0;
            rd_addr = AW'(kid_base + PW'(1));
         end
         OP_CH_CMP: begin
            // first child with the smallest key wins ties
            if (!found_ff || rd_data.key < best_e_ff.key) begin
               best_e_in = rd_data; best_in = kid_pos;
               found_in = 1'b1;
            end
            j_in = j_ff + JW'(1);
            rd_addr = AW'(kid_pos + PW'(1));
         end
         OP_DN_STEP: begin
            wr_en = 1'b1; wr_data = best_e_ff;
            pos_in = best_ff; j_in = JW'(1); found_in = 1'b0;
            rd_addr = AW'(best_base + PW'(1));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff <= CNT_W'(1024);
         pos_ff <= '0; best_ff <= '0; j_ff <= '0;
         cur_ff <= '0; best_e_ff <= '0; found_ff <= 1'b0;
         is_pop_ff <= 1'b0; rsp_ff <= '0;
      end else begin
         count_ff <= count_in;
         cap_ff <= cap_in;
         pos_ff <= pos_in; best_ff <= best_in; j_ff <= j_in;
         cur_ff <= cur_in; best_e_ff <= best_e_in; found_ff <= found_in;
         is_pop_ff <= is_pop_in; rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;
endmodule

// ===== rtl/fahq_ctrl.sv =====
// fahq_ctrl: sequencer for push sift-up and pop sift-down
// depends on fahq_pkg
`timescale 1ns / 1ps
module fahq_ctrl
   import fahq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_UP_CMP, S_WR_HOLE, S_TAKE_ROOT, S_LOAD_LAST,
      S_CH_CMP, S_DN_MOVE, S_RESP
   } state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE: if (req_fire) begin
            cmd.op = OP_LOAD; state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.is_pop) begin
               if (sts.empty) state_in = S_RESP;
               else begin
                  cmd.op = OP_RD_ROOT; state_in = S_TAKE_ROOT;
               end
            end else if (sts.full) begin
               cmd.op = OP_DROP; state_in = S_RESP;
            end else begin
               cmd.op = OP_PUSH_START;
               state_in = sts.at_root ? S_WR_HOLE : S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmd.op = OP_UP_STEP;
            state_in = (sts.up_swap && !sts.up_top) ? S_UP_CMP : S_WR_HOLE;
         end
         S_WR_HOLE: begin
            cmd.op = OP_WR_HOLE; state_in = S_RESP;
         end
         S_TAKE_ROOT: begin
            cmd.op = OP_TAKE_ROOT;
            state_in = sts.last_one ? S_RESP : S_LOAD_LAST;
         end
         S_LOAD_LAST: begin
            cmd.op = OP_LOAD_LAST;
            state_in = sts.child_first ? S_CH_CMP : S_WR_HOLE;
         end
         S_CH_CMP: begin
            cmd.op = OP_CH_CMP;
            state_in = sts.child_next ? S_CH_CMP : S_DN_MOVE;
         end
         S_DN_MOVE: begin
            if (sts.down_swap) begin
               cmd.op = OP_DN_STEP;
               state_in = sts.best_first ? S_CH_CMP : S_WR_HOLE;
            end else begin
               cmd.op = OP_WR_HOLE; state_in = S_RESP;
            end
         end
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_load: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_DECIDE) else $error("accept did not start");
   a_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready) else $error("no return to idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
endmodule

// ===== tb/tb_four_ary_min_heap_queue.sv =====
// tb_four_ary_min_heap_queue: self-checking bench for the 4-ary min-heap queue
// depends on fahq_pkg, fahq_if and the four_ary_min_heap_queue rtl
`timescale 1ns / 1ps
module tb_four_ary_min_heap_queue
   import fahq_pkg::*;
();
   localparam int DEPTH = 1024;
   localparam int REQ_W = $bits(req_type);
   localparam int RSP_W = $bits(rsp_type);
   localparam longint CYCLE_LIMIT = 64'd3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;

   fahq_if #(.W(REQ_W)) req ();
   fahq_if #(.W(RSP_W)) rsp ();

   four_ary_min_heap_queue #(.DEPTH(DEPTH)) u_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predicted heap contents
   entry_type heap_mirror [DEPTH];
   int unsigned heap_fill;
   int unsigned cap_setting;
   rsp_type expected_rsps [$];
   int error_count = 0;
   longint cycle_count = 0;
   bit send_gaps = 1'b1;
   bit recv_gaps = 1'b1;
   bit long_hold_req = 1'b0;
   bit long_hold_taken = 1'b0;
   int hold_off = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL four_ary_min_heap_queue");
         $finish;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void swap_slots(int unsigned a, int unsigned b);
      entry_type t;
      t = heap_mirror[a];
      heap_mirror[a] = heap_mirror[b];
      heap_mirror[b] = t;
   endfunction

   function automatic rsp_type predict_heap_op(req_type r);
      rsp_type o;
      int unsigned lim, pos, up, best, c;
      bit found;
      o = '0;
      lim = (cap_setting > DEPTH) ? DEPTH : cap_setting;
      if (r.kind == KIND_PUSH) begin
         if (heap_fill >= lim) o.push_dropped = 1'b1;
         else begin
            pos = heap_fill;
            heap_mirror[pos].tag = r.tag;
            heap_mirror[pos].key = r.key;
            while (pos > 0) begin
               up = (pos - 1) / ARITY;
               if (heap_mirror[pos].key < heap_mirror[up].key) begin
                  swap_slots(pos, up);
                  pos = up;
               end else break;
            end
            heap_fill++;
         end
      end else if (heap_fill > 0) begin
         o.out_tag = heap_mirror[0].tag;
         o.out_key = heap_mirror[0].key;
         o.pop_valid = 1'b1;
         heap_fill--;
         if (heap_fill > 0) begin
            heap_mirror[0] = heap_mirror[heap_fill];
            pos = 0;
            forever begin
               found = 1'b0;
               best = 0;
               for (int j = 1; j <= ARITY; j++) begin
                  c = ARITY * pos + j;
                  if (c >= heap_fill) break;
                  if (!found || heap_mirror[c].key < heap_mirror[best].key) begin
                     best = c;
                     found = 1'b1;
                  end
               end
               if (found && heap_mirror[best].key < heap_mirror[pos].key) begin
                  swap_slots(pos, best);
                  pos = best;
               end else break;
            end
         end
      end
      o.fill_count = heap_fill[CNT_W-1:0];
      return o;
   endfunction

   // valid stays high after an accept until the next item or a drain lowers it
   task automatic send_item(input logic kind, input logic [TAG_W-1:0] tag,
                            input logic [KEY_W-1:0] key);
      req_type r;
      int gap;
      r.kind = kind;
      r.tag = tag;
      r.key = key;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      expected_rsps.push_back(predict_heap_op(r));
   endtask

   task automatic push_item(input logic [TAG_W-1:0] tag, input logic [KEY_W-1:0] key);
      send_item(KIND_PUSH, tag, key);
   endtask

   task automatic pop_item();
      send_item(KIND_POP, logic'($urandom_range(0, 1)) ? 20'hFFFFF : 20'h0,
                KEY_W'($urandom()));
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_capacity(input int unsigned value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= value[CNT_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      cap_setting = value & 11'h7FF;
   endtask

   // receiver side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (long_hold_req && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         hold_off <= 300;
         rsp.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
         hold_off <= $urandom_range(0, 9);
         rsp.ready <= 1'b0;
      end else rsp.ready <= 1'b1;
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = rsp.data;
         if (expected_rsps.size() == 0) report("unexpected item", got, 64'd0);
         else begin
            want = expected_rsps.pop_front();
            if (got.out_tag !== want.out_tag)
               report("out_tag", 64'(got.out_tag), 64'(want.out_tag));
            if (got.out_key !== want.out_key)
               report("out_key", 64'(got.out_key), 64'(want.out_key));
            if (got.pop_valid !== want.pop_valid)
               report("pop_valid", 64'(got.pop_valid), 64'(want.pop_valid));
            if (got.push_dropped !== want.push_dropped)
               report("push_dropped", 64'(got.push_dropped), 64'(want.push_dropped));
            if (got.fill_count !== want.fill_count)
               report("fill_count", 64'(got.fill_count), 64'(want.fill_count));
         end
      end
   end

   task automatic test_directed();
      pop_item();
      push_item(20'hFFFFF, 31'h7FFFFFFF);
      push_item(20'h00000, 31'h0);
      push_item(20'h12345, 31'h0);
      push_item(20'hAAAAA, 31'h55555555);
      push_item(20'h55555, 31'h2AAAAAAA);
      push_item(20'h00001, 31'h7FFFFFFF);
      repeat (7) pop_item();
   endtask

   task automatic test_capacity_edges();
      write_capacity(0);
      push_item(20'h1, 31'h5);
      pop_item();
      write_capacity(3);
      repeat (5) push_item(TAG_W'($urandom()), KEY_W'($urandom_range(0, 20)));
      write_capacity(1);
      push_item(20'h7, 31'h7);
      repeat (2) pop_item();
      push_item(20'h8, 31'h1);
      pop_item();
      write_capacity(11'h7FF);
      repeat (2) pop_item();
   endtask

   task automatic test_backpressure();
      long_hold_req = 1'b1;
      repeat (8) push_item(TAG_W'($urandom()), KEY_W'($urandom()));
      repeat (8) pop_item();
   endtask

   task automatic test_random(input int count, input int unsigned key_max);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < (heap_fill < 20 ? 65 : 45))
            push_item(TAG_W'($urandom()), KEY_W'($urandom_range(0, key_max)));
         else pop_item();
      end
   endtask

   task automatic test_full_queue();
      write_capacity(12);
      repeat (16) push_item(TAG_W'($urandom()), KEY_W'($urandom_range(0, 7)));
      test_random(60, 31'h7FFFFFFF);
      write_capacity(5);
      test_random(40, 15);
      write_capacity(1024);
   endtask

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      heap_fill = 0;
      cap_setting = 1024;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity_edges();
      test_backpressure();
      test_random(250, 31'h7FFFFFFF);
      test_random(150, 31);
      test_full_queue();
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      test_random(150, 31'h7FFFFFFF);
      drain_results();
      if (error_count == 0) $display("PASS four_ary_min_heap_queue");
      else $display("FAIL four_ary_min_heap_queue");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/fahq_pkg.sv
rtl/fahq_if.sv
rtl/fahq_ram.sv
rtl/fahq_dp.sv
rtl/fahq_ctrl.sv
rtl/four_ary_min_heap_queue.sv
tb/tb_four_ary_min_heap_queue.sv
